>>> rtl/led_color_datagram_framer_defines.svh
// Assertion macros shared by the framer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef LED_COLOR_DATAGRAM_FRAMER_DEFINES_SVH
`define LED_COLOR_DATAGRAM_FRAMER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define LCDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define LCDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCDF_ASSERT(lbl, prop, msg)
`define LCDF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/lcdf_pkg.sv
// Shared constants and types of the LED datagram framer.
// No dependencies; imported by every framer module.
`timescale 1ns / 1ps
package lcdf_pkg;

  localparam int MAX_FRAME_LEDS = 4096;
  localparam int FRAG_LEDS      = 450;
  localparam int BYTE_CAP       = 4090;
  localparam int LIST_DEPTH     = 10;

  localparam logic [1:0] MODE_RAW    = 2'd0;
  localparam logic [1:0] MODE_FRAG   = 2'd1;
  localparam logic [1:0] MODE_COUNT  = 2'd2;
  localparam logic [1:0] MODE_FRAMED = 2'd3;

  localparam logic REG_PROTOCOL_MODE   = 1'b0;
  localparam logic REG_LEDS_PER_PACKET = 1'b1;

  localparam logic [7:0] HDR_SYNC0 = 8'h9C;
  localparam logic [7:0] HDR_SYNC1 = 8'hDA;
  localparam logic [7:0] TRAILER   = 8'h36;

  // One queued result byte
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       dend;
    logic       rlast;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic div_start;
    logic plan;
    logic load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic first;
    logic div_busy;
    logic n_zero;
    logic at_end;
    logic out_space;
  } sts_t;

endpackage

>>> rtl/led_color_datagram_framer.sv
// Top level of the LED color datagram framer.
// Depends on lcdf_pkg, lcdf_ctrl and lcdf_datapath.
//
// Use: one LED per s_axis transaction (red, green, blue, frame LED count).
// The block answers with zero to ten m_axis transactions, one datagram byte
// each; tlast marks the final byte of a datagram, tuser[0] says the byte
// carries data (0 for a bare end mark), tuser[1] marks the last byte caused
// by this LED. The cfg channel writes protocol_mode (index 0) and
// leds_per_packet (index 1) and is always ready; write it only while idle.
// Sequence: the LED is registered at accept; at the first LED of a frame a
// one-bit-per-cycle divider then works out the fragment total. The plan
// state builds the result list, and the byte sequencer walks it into the
// output register, one byte a cycle while the receiver keeps up; a new LED
// is taken only once the whole list has been loaded.
// A single output register parts the two sides: the next LED is accepted
// while the last byte still waits. When the receiver stalls, the byte held
// stays and the sequencer waits. Reset (rst, synchronous) clears the frame
// state, the output register and restores mode 0 and 200 LEDs per packet.
`timescale 1ns / 1ps
module led_color_datagram_framer import lcdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // red [7:0], green [15:8], blue [23:16], frame_led_count [36:24], zero fill
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte [7:0]
  output logic [7:0]  m_axis_tdata,
  // byte_valid [0], run_last [1]
  output logic [1:0]  m_axis_tuser,
  // datagram_end
  output logic        m_axis_tlast
);

  cmd_t   cmd;
  sts_t   sts;
  entry_t out_entry;

  assign cfg_ready = 1'b1;

  lcdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcdf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_red    (s_axis_tdata[7:0]),
    .in_green  (s_axis_tdata[15:8]),
    .in_blue   (s_axis_tdata[23:16]),
    .in_count  (s_axis_tdata[36:24]),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_entry (out_entry)
  );

  assign m_axis_tdata = out_entry.data;
  assign m_axis_tuser = {out_entry.rlast, out_entry.valid};
  assign m_axis_tlast = out_entry.dend;

endmodule

>>> rtl/lcdf_div.sv
// Restoring divider, one quotient bit per cycle, for the fragment total.
// Depends on lcdf_pkg.
`timescale 1ns / 1ps
module lcdf_div import lcdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [12:0] dividend,
  input  logic [10:0] divisor,
  output logic        busy,
  output logic [12:0] quotient
);

  logic [12:0] num;
  logic [10:0] rem;
  logic [10:0] den;
  logic [3:0]  step;
  logic [11:0] rem_s;
  logic        ge;

  assign rem_s = {rem, num[12]};
  assign ge    = rem_s >= {1'b0, den};

  // Control: count thirteen steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 4'd0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 4'd12;
    end else if (busy) begin
      if (step == 4'd0) busy <= 1'b0;
      step <= step - 4'd1;
    end
  end

  // Datapath: shift, compare, subtract
  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= 11'd0;
      quotient <= 13'd0;
    end else if (busy) begin
      num      <= {num[11:0], 1'b0};
      quotient <= {quotient[11:0], ge};
      rem      <= ge ? 11'(rem_s - {1'b0, den}) : rem_s[10:0];
    end
  end

endmodule

>>> rtl/lcdf_datapath.sv
// Datapath of the framer: registers, frame state, result list, output register.
// Depends on lcdf_pkg and lcdf_div.
`timescale 1ns / 1ps
module lcdf_datapath import lcdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [12:0] in_count,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        out_ready,
  output logic        out_valid,
  output entry_t      out_entry
);

  logic [1:0]  mode;
  logic [10:0] lpp;
  logic [10:0] lpp_eff;
  logic [3:0]  frame_counter;
  logic [12:0] led_index;
  logic [7:0]  fragment_counter;
  logic [12:0] datagram_bytes;
  logic [10:0] leds_in_packet;
  logic [7:0]  total_fragments;
  logic [8:0]  pos;
  logic [3:0]  frag;
  logic [7:0]  r_q, g_q, b_q;
  logic [12:0] cnt_q;
  logic [12:0] cnt_clamp;
  logic [12:0] quotient;
  logic [12:0] quot_inc;
  logic [7:0]  tf_div;
  logic        div_busy;
  entry_t      lst_q [LIST_DEPTH];
  logic [3:0]  n_q;
  logic [3:0]  ptr;

  // Plan outputs
  entry_t      lst [LIST_DEPTH];
  logic [3:0]  n;
  logic        first, last;
  logic [3:0]  fc;
  logic [7:0]  fr, tf;
  logic [12:0] db;
  logic [10:0] lip;
  logic [13:0] size;
  logic [15:0] off;

  function automatic entry_t mk(input logic [7:0] d, input logic v);
    entry_t e;
    e.data  = d;
    e.valid = v;
    e.dend  = 1'b0;
    e.rlast = 1'b0;
    return e;
  endfunction

  function automatic logic [15:0] frag_offset(input logic [1:0] k);
    logic [15:0] o;
    case (k)
      2'd0:    o = 16'd0;
      2'd1:    o = 16'(FRAG_LEDS);
      2'd2:    o = 16'(2 * FRAG_LEDS);
      default: o = 16'(3 * FRAG_LEDS);
    endcase
    return o;
  endfunction

  assign lpp_eff   = (lpp == 11'd0) ? 11'd1 : lpp;
  assign cnt_clamp = (in_count > 13'(MAX_FRAME_LEDS)) ? 13'(MAX_FRAME_LEDS) : in_count;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RAW;
      lpp  <= 11'd200;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PROTOCOL_MODE) mode <= cfg_data[1:0];
      else                                lpp  <= cfg_data;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_q   <= in_red;
      g_q   <= in_green;
      b_q   <= in_blue;
      cnt_q <= cnt_clamp;
    end
  end

  lcdf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cnt_clamp),
    .divisor  (lpp_eff),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign quot_inc = quotient + 13'd1;
  assign tf_div   = (cnt_q > {2'b00, lpp_eff}) ? quot_inc[7:0] : 8'd1;

  // Build the result list of one LED
  always_comb begin
    first = (led_index == 13'd0);
    last  = ({1'b0, led_index} + 14'd1) >= {1'b0, cnt_q};
    fc    = first ? frame_counter + 4'd1 : frame_counter;
    fr    = first ? ((mode == MODE_FRAMED) ? 8'd1 : 8'd0) : fragment_counter;
    db    = first ? 13'd0 : datagram_bytes;
    lip   = first ? 11'd0 : leds_in_packet;
    tf    = first ? tf_div : total_fragments;
    size  = {1'b0, cnt_q} + {cnt_q, 1'b0};
    off   = frag_offset(frag[1:0]);
    n     = 4'd0;
    for (int i = 0; i < LIST_DEPTH; i++) lst[i] = mk(8'd0, 1'b0);

    case (mode)
      MODE_RAW: begin
        if (db < 13'(BYTE_CAP)) begin
          lst[n] = mk(r_q, 1'b1); n = n + 4'd1;
          lst[n] = mk(g_q, 1'b1); n = n + 4'd1;
          lst[n] = mk(b_q, 1'b1); n = n + 4'd1;
          db = db + 13'd3;
        end
        if (last) begin
          if (n == 4'd0) begin
            lst[n] = mk(8'd0, 1'b0); n = n + 4'd1;
          end
          lst[n - 4'd1].dend = 1'b1;
          db = 13'd0; lip = 11'd0;
        end
      end
      MODE_FRAG: begin
        if (pos == 9'd0) begin
          db = 13'd0;
          if (frag < 4'd4 && !last) begin
            lst[n] = mk(8'd0, 1'b1);    n = n + 4'd1;
            lst[n] = mk(8'd0, 1'b1);    n = n + 4'd1;
            lst[n] = mk(off[15:8], 1'b1); n = n + 4'd1;
            lst[n] = mk(off[7:0], 1'b1);  n = n + 4'd1;
            db = 13'd4;
          end
        end
        if (db != 13'd0) begin
          if (db < 13'(BYTE_CAP)) begin
            lst[n] = mk(r_q, 1'b1); n = n + 4'd1;
            lst[n] = mk(g_q, 1'b1); n = n + 4'd1;
            lst[n] = mk(b_q, 1'b1); n = n + 4'd1;
            db = db + 13'd3;
          end
          if (pos == 9'(FRAG_LEDS - 1) || last) begin
            if (n == 4'd0) begin
              lst[n] = mk(8'd0, 1'b0); n = n + 4'd1;
            end
            lst[n - 4'd1].dend = 1'b1;
            db = 13'd0; lip = 11'd0;
          end
        end
      end
      MODE_COUNT: begin
        if (db == 13'd0) begin
          lst[n] = mk({4'd0, fc}, 1'b1);          n = n + 4'd1;
          lst[n] = mk(fr, 1'b1);                  n = n + 4'd1;
          lst[n] = mk({3'd0, led_index[12:8]}, 1'b1); n = n + 4'd1;
          lst[n] = mk(led_index[7:0], 1'b1);      n = n + 4'd1;
          db = 13'd4;
        end
        if (db < 13'(BYTE_CAP)) begin
          lst[n] = mk(r_q, 1'b1); n = n + 4'd1;
          lst[n] = mk(g_q, 1'b1); n = n + 4'd1;
          lst[n] = mk(b_q, 1'b1); n = n + 4'd1;
          db = db + 13'd3;
        end
        lip = lip + 11'd1;
        if (lip >= lpp_eff || last) begin
          // A full datagram that drops this LED still needs an end mark
          if (n == 4'd0) begin
            lst[n] = mk(8'd0, 1'b0); n = n + 4'd1;
          end
          lst[n - 4'd1].dend = 1'b1;
          db = 13'd0; lip = 11'd0;
          fr = fr + 8'd1;
        end
      end
      default: begin
        if (db == 13'd0) begin
          lst[n] = mk(HDR_SYNC0, 1'b1);          n = n + 4'd1;
          lst[n] = mk(HDR_SYNC1, 1'b1);          n = n + 4'd1;
          lst[n] = mk({2'd0, size[13:8]}, 1'b1); n = n + 4'd1;
          lst[n] = mk(size[7:0], 1'b1);          n = n + 4'd1;
          lst[n] = mk(fr, 1'b1);                 n = n + 4'd1;
          lst[n] = mk(tf, 1'b1);                 n = n + 4'd1;
          db = 13'd6;
        end
        if (db < 13'(BYTE_CAP)) begin
          lst[n] = mk(r_q, 1'b1); n = n + 4'd1;
          lst[n] = mk(g_q, 1'b1); n = n + 4'd1;
          lst[n] = mk(b_q, 1'b1); n = n + 4'd1;
          db = db + 13'd3;
        end
        lip = lip + 11'd1;
        if (lip >= lpp_eff || last) begin
          lst[n] = mk(TRAILER, 1'b1); n = n + 4'd1;
          lst[n - 4'd1].dend = 1'b1;
          db = 13'd0; lip = 11'd0;
          fr = fr + 8'd1;
        end
      end
    endcase

    if (n != 4'd0) lst[n - 4'd1].rlast = 1'b1;
  end

  // Commit the frame state and store the list
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter    <= 4'd0;
      led_index        <= 13'd0;
      fragment_counter <= 8'd0;
      datagram_bytes   <= 13'd0;
      leds_in_packet   <= 11'd0;
      total_fragments  <= 8'd0;
      pos              <= 9'd0;
      frag             <= 4'd0;
      n_q              <= 4'd0;
      ptr              <= 4'd0;
    end else if (cmd.plan) begin
      frame_counter    <= fc;
      fragment_counter <= fr;
      datagram_bytes   <= db;
      leds_in_packet   <= lip;
      total_fragments  <= tf;
      n_q              <= n;
      ptr              <= 4'd0;
      if (last) begin
        led_index <= 13'd0;
        pos       <= 9'd0;
        frag      <= 4'd0;
      end else begin
        led_index <= led_index + 13'd1;
        if (pos == 9'(FRAG_LEDS - 1)) begin
          pos  <= 9'd0;
          frag <= frag + 4'd1;
        end else begin
          pos <= pos + 9'd1;
        end
      end
    end else if (cmd.load) begin
      ptr <= ptr + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      for (int i = 0; i < LIST_DEPTH; i++) lst_q[i] <= lst[i];
    end
  end

  // Output register: load on command, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) out_entry <= lst_q[ptr];
  end

  // Report status to the controller
  always_comb begin
    sts.first     = (led_index == 13'd0);
    sts.div_busy  = div_busy;
    sts.n_zero    = (n == 4'd0);
    sts.at_end    = (ptr == n_q - 4'd1);
    sts.out_space = !out_valid || out_ready;
  end

endmodule

>>> rtl/lcdf_ctrl.sv
// Controller of the framer: sequences accept, divide, plan and emit.
// Depends on lcdf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "led_color_datagram_framer_defines.svh"
module lcdf_ctrl import lcdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_PLAN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state, state_next;
  logic       in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd.latch     = 1'b0;
    cmd.div_start = 1'b0;
    cmd.plan      = 1'b0;
    cmd.load      = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.latch     = 1'b1;
          cmd.div_start = sts.first;
          state_next    = sts.first ? S_DIV : S_PLAN;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) state_next = S_PLAN;
      end
      S_PLAN: begin
        cmd.plan   = 1'b1;
        state_next = sts.n_zero ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_space) begin
          cmd.load = 1'b1;
          if (sts.at_end) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  `LCDF_ASSERT(a_load_space, cmd.load |-> sts.out_space, "load into a full output register")
  `LCDF_ASSERT(a_empty_list, (state == S_PLAN && sts.n_zero) |=> (state == S_IDLE),
               "empty list did not return to idle")
  `LCDF_ASSERT(a_div_wait, (state == S_DIV && sts.div_busy) |=> !in_ready,
               "input accepted while dividing")
  `LCDF_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE), "state not idle after reset")

endmodule
